// ===== design/hsv_pkg.sv =====
// hsv_pkg: shared types and constants of the hsv to rgb converter
// used by hsv_chan and hsv_to_rgb, no dependencies
package hsv_pkg;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned Q16_W   = 17;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned WRAP_W  = 15;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned PROD_W  = Q16_W + FRAC_W;
  localparam int unsigned TERM_W  = 28;
  localparam int unsigned MUL_W   = Q16_W + TERM_W;
  localparam int unsigned SCALE_W = MUL_W + 5;
  localparam int unsigned SHIFT   = 40;
  localparam int unsigned NSTAGE  = 6;

  localparam int unsigned HUE_BIAS    = 46080;
  localparam int unsigned HUE_TURN    = 23040;
  localparam int unsigned SECTOR_SPAN = 3840;
  localparam int unsigned TERM_FULL   = 65536 * SECTOR_SPAN;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } hsv_sector_e;

  typedef struct packed {
    logic prod;
    logic term;
    logic mul;
  } hsv_adv_t;

endpackage

// ===== design/hsv_chan.sv =====
// hsv_chan: one output channel, v * (1 - s*m/3840) scaled by 255, clamped
// three register stages: s*m product, term with sign check, v*term product
// depends on hsv_pkg
module hsv_chan (
  input  logic                                clk_i,
  input  hsv_pkg::hsv_adv_t                   adv_i,
  input  logic [hsv_pkg::Q16_W-1:0]           sat_i,
  input  logic [hsv_pkg::FRAC_W-1:0]          m_i,
  input  logic [hsv_pkg::Q16_W-1:0]           val_i,
  output logic [hsv_pkg::CHAN_W-1:0]         chan_o
);

  logic [hsv_pkg::PROD_W-1:0]   prod_q;
  logic signed [hsv_pkg::PROD_W:0] term_full;
  logic                          term_pos;
  logic [hsv_pkg::TERM_W-1:0]   term_d, term_q;
  logic [hsv_pkg::MUL_W-1:0]    mul_q;
  logic [hsv_pkg::SCALE_W-1:0]  scaled;

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      prod_q <= hsv_pkg::PROD_W'(sat_i * m_i);
    end
  end

  // term goes negative when s*m/3840 exceeds one, and is then clamped to zero
  always_comb begin
    term_full = (hsv_pkg::PROD_W+1)'(hsv_pkg::TERM_FULL) - {1'b0, prod_q};
    term_pos  = !term_full[hsv_pkg::PROD_W] && (term_full != '0);
    term_d    = term_pos ? term_full[hsv_pkg::TERM_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.term) begin
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      mul_q <= hsv_pkg::MUL_W'(val_i * term_q);
    end
  end

  // 255 / (3840 * 2^32) = 17 / 2^40
  always_comb begin
    scaled = {1'b0, mul_q, 4'b0000} + hsv_pkg::SCALE_W'(mul_q);
    if (|scaled[hsv_pkg::SCALE_W-1:hsv_pkg::SHIFT+hsv_pkg::CHAN_W]) begin
      chan_o = hsv_pkg::CHAN_MAX;
    end else begin
      chan_o = scaled[hsv_pkg::SHIFT+hsv_pkg::CHAN_W-1:hsv_pkg::SHIFT];
    end
  end

endmodule

// ===== design/hsv_to_rgb.sv =====
// hsv_to_rgb: hsv pixel to 8-bit rgb converter, six-stage pipeline
// each input transfer reaches output valid through the stage chain, one pixel per cycle while out_stall_i is low
// stage chain: hue wrap, sector split, s*m, term, v*term, scale and sector select
// each stage advances when empty or when the next one advances
// reset clears the stage valid bits only, payload registers are not reset
// depends on hsv_pkg and hsv_chan
module hsv_to_rgb (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [hsv_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsv_pkg::Q16_W-1:0]          saturation_i,
  input  logic [hsv_pkg::Q16_W-1:0]          brightness_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hsv_pkg::CHAN_W-1:0]         red_o,
  output logic [hsv_pkg::CHAN_W-1:0]         green_o,
  output logic [hsv_pkg::CHAN_W-1:0]         blue_o
);

  localparam int unsigned N = hsv_pkg::NSTAGE;

  logic [N-1:0] vld_d, vld_q, en;
  hsv_pkg::hsv_adv_t adv;

  logic [hsv_pkg::Q16_W-1:0]   hx;
  logic [hsv_pkg::WRAP_W-1:0]  hw_d, hw_q;
  logic [hsv_pkg::Q16_W-1:0]   s0_q, v0_q, s1_q, v1_q, v2_q, v3_q;
  hsv_pkg::hsv_sector_e        sect_d, sect1_q, sect2_q, sect3_q, sect4_q;
  logic [hsv_pkg::FRAC_W-1:0]  k_d, k_q, mt;
  logic [hsv_pkg::CHAN_W-1:0]  cv, cp, cq, ct;
  logic [hsv_pkg::CHAN_W-1:0]  red_d, green_d, blue_d, red_q, green_q, blue_q;

  // stage enables
  always_comb begin
    en[N-1] = !vld_q[N-1] || !out_stall_i;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < N; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[N-1];

  // stage 0: wrap hue into one turn
  always_comb begin
    hx = hsv_pkg::Q16_W'({hue_i[hsv_pkg::HUE_W-1], hue_i}) + hsv_pkg::Q16_W'(hsv_pkg::HUE_BIAS);
    if (hx >= hsv_pkg::Q16_W'(3 * hsv_pkg::HUE_TURN)) begin
      hw_d = hsv_pkg::WRAP_W'(hx - hsv_pkg::Q16_W'(3 * hsv_pkg::HUE_TURN));
    end else if (hx >= hsv_pkg::Q16_W'(2 * hsv_pkg::HUE_TURN)) begin
      hw_d = hsv_pkg::WRAP_W'(hx - hsv_pkg::Q16_W'(2 * hsv_pkg::HUE_TURN));
    end else if (hx >= hsv_pkg::Q16_W'(hsv_pkg::HUE_TURN)) begin
      hw_d = hsv_pkg::WRAP_W'(hx - hsv_pkg::Q16_W'(hsv_pkg::HUE_TURN));
    end else begin
      hw_d = hsv_pkg::WRAP_W'(hx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hw_q <= hw_d;
      s0_q <= saturation_i;
      v0_q <= brightness_i;
    end
  end

  // stage 1: sector and fraction
  always_comb begin
    if (hw_q >= hsv_pkg::WRAP_W'(5 * hsv_pkg::SECTOR_SPAN)) begin
      sect_d = hsv_pkg::SECT_MAG_RED;
      k_d    = hsv_pkg::FRAC_W'(hw_q - hsv_pkg::WRAP_W'(5 * hsv_pkg::SECTOR_SPAN));
    end else if (hw_q >= hsv_pkg::WRAP_W'(4 * hsv_pkg::SECTOR_SPAN)) begin
      sect_d = hsv_pkg::SECT_BLU_MAG;
      k_d    = hsv_pkg::FRAC_W'(hw_q - hsv_pkg::WRAP_W'(4 * hsv_pkg::SECTOR_SPAN));
    end else if (hw_q >= hsv_pkg::WRAP_W'(3 * hsv_pkg::SECTOR_SPAN)) begin
      sect_d = hsv_pkg::SECT_CYN_BLU;
      k_d    = hsv_pkg::FRAC_W'(hw_q - hsv_pkg::WRAP_W'(3 * hsv_pkg::SECTOR_SPAN));
    end else if (hw_q >= hsv_pkg::WRAP_W'(2 * hsv_pkg::SECTOR_SPAN)) begin
      sect_d = hsv_pkg::SECT_GRN_CYN;
      k_d    = hsv_pkg::FRAC_W'(hw_q - hsv_pkg::WRAP_W'(2 * hsv_pkg::SECTOR_SPAN));
    end else if (hw_q >= hsv_pkg::WRAP_W'(hsv_pkg::SECTOR_SPAN)) begin
      sect_d = hsv_pkg::SECT_YEL_GRN;
      k_d    = hsv_pkg::FRAC_W'(hw_q - hsv_pkg::WRAP_W'(hsv_pkg::SECTOR_SPAN));
    end else begin
      sect_d = hsv_pkg::SECT_RED_YEL;
      k_d    = hsv_pkg::FRAC_W'(hw_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sect1_q <= sect_d;
      k_q     <= k_d;
      s1_q    <= s0_q;
      v1_q    <= v0_q;
    end
  end

  assign mt = hsv_pkg::FRAC_W'(hsv_pkg::SECTOR_SPAN) - k_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sect2_q <= sect1_q;
      v2_q    <= v1_q;
    end
    if (en[3]) begin
      sect3_q <= sect2_q;
      v3_q    <= v2_q;
    end
    if (en[4]) begin
      sect4_q <= sect3_q;
    end
  end

  // stages 2 to 4: channel terms
  assign adv.prod = en[2];
  assign adv.term = en[3];
  assign adv.mul  = en[4];

  hsv_chan u_chan_v (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sat_i  (s1_q),
    .m_i    ('0),
    .val_i  (v3_q),
    .chan_o (cv)
  );

  hsv_chan u_chan_p (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sat_i  (s1_q),
    .m_i    (hsv_pkg::FRAC_W'(hsv_pkg::SECTOR_SPAN)),
    .val_i  (v3_q),
    .chan_o (cp)
  );

  hsv_chan u_chan_q (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sat_i  (s1_q),
    .m_i    (k_q),
    .val_i  (v3_q),
    .chan_o (cq)
  );

  hsv_chan u_chan_t (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .sat_i  (s1_q),
    .m_i    (mt),
    .val_i  (v3_q),
    .chan_o (ct)
  );

  // stage 5: pick channels by sector
  always_comb begin
    case (sect4_q)
      hsv_pkg::SECT_RED_YEL: begin
        red_d = cv; green_d = ct; blue_d = cp;
      end
      hsv_pkg::SECT_YEL_GRN: begin
        red_d = cq; green_d = cv; blue_d = cp;
      end
      hsv_pkg::SECT_GRN_CYN: begin
        red_d = cp; green_d = cv; blue_d = ct;
      end
      hsv_pkg::SECT_CYN_BLU: begin
        red_d = cp; green_d = cq; blue_d = cv;
      end
      hsv_pkg::SECT_BLU_MAG: begin
        red_d = ct; green_d = cp; blue_d = cv;
      end
      default: begin
        red_d = cv; green_d = cp; blue_d = cq;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  a_no_stall_free_path : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_hue_wrapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (hw_q < hsv_pkg::WRAP_W'(hsv_pkg::HUE_TURN)))
    else $error("wrapped hue out of range");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (k_q < hsv_pkg::FRAC_W'(hsv_pkg::SECTOR_SPAN)))
    else $error("sector fraction out of range");

  a_value_largest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (cv >= cp) && (cv >= cq) && (cv >= ct))
    else $error("value channel below another channel");

endmodule
